[rtl/im2col_tile_element_gather_defines.svh]
// ----------------------------------------------------------------------------
// im2col tile element gather assertion macros
// shared assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef IM2COL_TILE_ELEMENT_GATHER_DEFINES_SVH
`define IM2COL_TILE_ELEMENT_GATHER_DEFINES_SVH

`ifndef SYNTHESIS
`define I2CTG_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);
`define I2CTG_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);
`else
`define I2CTG_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg)
`define I2CTG_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg)
`endif

`endif

[rtl/i2ctg_pkg.sv]
// ----------------------------------------------------------------------------
// i2ctg_pkg
// fixed field widths, command codes and register indexes of the gather block
// ----------------------------------------------------------------------------
package i2ctg_pkg;

    localparam int PATCH_W  = 16;
    localparam int KIDX_W   = 14;
    localparam int WADDR_W  = 14;
    localparam int WORD_W   = 32;
    localparam int START_W  = 12;
    localparam int TDIM_W   = 7;
    localparam int KDIM_W   = 5;
    localparam int CHAN_W   = 7;
    localparam int ODIM_W   = 9;
    localparam int SMALL_W  = 4;
    localparam int TAPS_W   = 10;
    localparam int NPATCH_W = 18;
    localparam int KTOT_W   = 17;
    localparam int CFG_W    = 9;
    localparam int CFGI_W   = 3;
    localparam int LOC_W    = 24;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_GATHER = 1'b1;

    localparam logic [CFGI_W-1:0] REG_KERNEL_HEIGHT   = 3'd0;
    localparam logic [CFGI_W-1:0] REG_KERNEL_WIDTH    = 3'd1;
    localparam logic [CFGI_W-1:0] REG_INPUT_CHANNELS  = 3'd2;
    localparam logic [CFGI_W-1:0] REG_OUTPUT_HEIGHT   = 3'd3;
    localparam logic [CFGI_W-1:0] REG_OUTPUT_WIDTH    = 3'd4;
    localparam logic [CFGI_W-1:0] REG_CONV_STRIDE     = 3'd5;
    localparam logic [CFGI_W-1:0] REG_EDGE_PADDING    = 3'd6;
    localparam logic [CFGI_W-1:0] REG_KERNEL_DILATION = 3'd7;

endpackage

[rtl/i2ctg_ram.sv]
// ----------------------------------------------------------------------------
// i2ctg_ram
// generic single clock ram, one write and one read address, registered read
// ----------------------------------------------------------------------------
module i2ctg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/i2ctg_div.sv]
// ----------------------------------------------------------------------------
// i2ctg_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module i2ctg_div #(
    parameter int NW = 16,
    parameter int DW = 9
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [NW-1:0] quotient,
    output logic [DW-1:0] remainder
);

    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] wk_reg  [NW];
    logic [DW-1:0] dv_reg  [NW];

    genvar i;
    generate
        for (i = 0; i < NW; i++)
        begin : g_stage
            logic [DW-1:0] rem_in;
            logic [NW-1:0] wk_in;
            logic [DW-1:0] dv_in;
            logic [DW:0]   trial;
            logic          ge;
            logic [DW-1:0] rem_next;
            logic [NW-1:0] wk_next;

            if (i == 0)
            begin : g_first
                assign rem_in = '0;
                assign wk_in  = dividend;
                assign dv_in  = divisor;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[i-1];
                assign wk_in  = wk_reg[i-1];
                assign dv_in  = dv_reg[i-1];
            end

            always_comb
            begin
                trial    = {rem_in, wk_in[NW-1]};
                ge       = (trial >= {1'b0, dv_in});
                rem_next = ge ? DW'(trial - {1'b0, dv_in}) : trial[DW-1:0];
                // dividend bits leave at the top, quotient bits enter at the bottom
                wk_next  = {wk_in[NW-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= rem_next;
                    wk_reg[i]  <= wk_next;
                    dv_reg[i]  <= dv_in;
                end
            end
        end
    endgenerate

    assign quotient  = wk_reg[NW-1];
    assign remainder = rem_reg[NW-1];

endmodule

[rtl/im2col_tile_element_gather.sv]
// ----------------------------------------------------------------------------
// im2col_tile_element_gather
// im2col element gather over a raw input tile scratchpad with stride,
// padding and dilation
// ----------------------------------------------------------------------------
// pipeline: two chained bit-per-stage divider pipelines (16 stages, then 10)
//   plus three stages for tile mapping, address and the scratchpad read
// throughput: one item per cycle; the whole pipeline holds while a result waits
// reset: clears configuration to defaults and all valid bits; scratchpad
//   contents stay undefined until written
`include "im2col_tile_element_gather_defines.svh"

module im2col_tile_element_gather #(
    parameter int STORE_DEPTH  = 16384,
    parameter int MAX_TILE_DIM = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [i2ctg_pkg::CFGI_W-1:0]          cfg_index,
    input  logic [i2ctg_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  cmd,
    input  logic [i2ctg_pkg::WADDR_W-1:0]         write_address,
    input  logic [i2ctg_pkg::WORD_W-1:0]          write_value,
    input  logic [i2ctg_pkg::PATCH_W-1:0]         patch_index,
    input  logic [i2ctg_pkg::KIDX_W-1:0]          kernel_index,
    input  logic signed [i2ctg_pkg::START_W-1:0]  tile_start_row,
    input  logic signed [i2ctg_pkg::START_W-1:0]  tile_start_col,
    input  logic [i2ctg_pkg::TDIM_W-1:0]          tile_rows,
    input  logic [i2ctg_pkg::TDIM_W-1:0]          tile_cols,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [i2ctg_pkg::WORD_W-1:0]          element_value,
    output logic                                  is_padding,
    output logic                                  beyond_store
);

    localparam int DIM_W  = $clog2(MAX_TILE_DIM + 1);
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int AF_W   = i2ctg_pkg::PATCH_W + 2 * DIM_W + 1;
    localparam int MID    = i2ctg_pkg::PATCH_W;
    localparam int LAST   = i2ctg_pkg::PATCH_W + i2ctg_pkg::TAPS_W;
    localparam logic [AF_W-1:0] DEPTH_AF = AF_W'(STORE_DEPTH);
    localparam logic [31:0]     MAX_DIM32 = 32'(MAX_TILE_DIM);

    typedef struct packed {
        logic                              cmd;
        logic [i2ctg_pkg::WADDR_W-1:0]     waddr;
        logic [i2ctg_pkg::WORD_W-1:0]      wval;
        logic [i2ctg_pkg::PATCH_W-1:0]     patch;
        logic [i2ctg_pkg::KIDX_W-1:0]      kidx;
        logic [i2ctg_pkg::START_W-1:0]     row0;
        logic [i2ctg_pkg::START_W-1:0]     col0;
        logic [DIM_W-1:0]                  trows;
        logic [DIM_W-1:0]                  tcols;
        logic [i2ctg_pkg::PATCH_W-1:0]     o_row;
        logic [i2ctg_pkg::ODIM_W-1:0]      o_col;
        logic [i2ctg_pkg::PATCH_W-1:0]     chan;
        logic                              pad;
    } meta_t;

    typedef struct packed {
        logic                              cmd;
        logic [i2ctg_pkg::WADDR_W-1:0]     waddr;
        logic [i2ctg_pkg::WORD_W-1:0]      wval;
        logic                              pad;
        logic [i2ctg_pkg::PATCH_W-1:0]     chan;
        logic [DIM_W-1:0]                  lrow;
        logic [DIM_W-1:0]                  lcol;
        logic [DIM_W-1:0]                  tcols;
        logic [2*DIM_W-1:0]                area;
    } map_t;

    typedef struct packed {
        logic                              cmd;
        logic [i2ctg_pkg::WORD_W-1:0]      wval;
        logic                              pad;
        logic                              beyond;
        logic [ADDR_W-1:0]                 addr;
    } acc_t;

    typedef struct packed {
        logic pad;
        logic beyond;
        logic keep;
    } res_t;

    // configuration
    logic [i2ctg_pkg::KDIM_W-1:0]   kh_reg, kw_reg;
    logic [i2ctg_pkg::CHAN_W-1:0]   ic_reg;
    logic [i2ctg_pkg::ODIM_W-1:0]   oh_reg, ow_reg;
    logic [i2ctg_pkg::SMALL_W-1:0]  stride_reg, epad_reg, dil_reg;
    logic [i2ctg_pkg::TAPS_W-1:0]   taps_reg;
    logic [i2ctg_pkg::NPATCH_W-1:0] npatch_reg;
    logic [i2ctg_pkg::KTOT_W-1:0]   ktot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kh_reg     <= 5'd3;
            kw_reg     <= 5'd3;
            ic_reg     <= 7'd1;
            oh_reg     <= 9'd30;
            ow_reg     <= 9'd30;
            stride_reg <= 4'd1;
            epad_reg   <= 4'd0;
            dil_reg    <= 4'd1;
            taps_reg   <= 10'd9;
            npatch_reg <= 18'd900;
            ktot_reg   <= 17'd9;
        end
        else
        begin
            taps_reg   <= i2ctg_pkg::TAPS_W'(kh_reg) * i2ctg_pkg::TAPS_W'(kw_reg);
            npatch_reg <= i2ctg_pkg::NPATCH_W'(oh_reg) * i2ctg_pkg::NPATCH_W'(ow_reg);
            ktot_reg   <= i2ctg_pkg::KTOT_W'(ic_reg) * i2ctg_pkg::KTOT_W'(taps_reg);
            if (cfg_write_en)
            begin
                case (cfg_index)
                    i2ctg_pkg::REG_KERNEL_HEIGHT:   kh_reg     <= cfg_data[4:0];
                    i2ctg_pkg::REG_KERNEL_WIDTH:    kw_reg     <= cfg_data[4:0];
                    i2ctg_pkg::REG_INPUT_CHANNELS:  ic_reg     <= cfg_data[6:0];
                    i2ctg_pkg::REG_OUTPUT_HEIGHT:   oh_reg     <= cfg_data[8:0];
                    i2ctg_pkg::REG_OUTPUT_WIDTH:    ow_reg     <= cfg_data[8:0];
                    i2ctg_pkg::REG_CONV_STRIDE:     stride_reg <= cfg_data[3:0];
                    i2ctg_pkg::REG_EDGE_PADDING:    epad_reg   <= cfg_data[3:0];
                    i2ctg_pkg::REG_KERNEL_DILATION: dil_reg    <= cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    // pipeline advance
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // decode stages alongside the dividers
    meta_t meta_reg  [LAST+1];
    meta_t meta_next [LAST+1];
    logic  vld_reg   [LAST+1];
    logic  vld_next  [LAST+1];

    logic [DIM_W-1:0] trows_sat, tcols_sat;

    logic [i2ctg_pkg::PATCH_W-1:0] qa, qb;
    logic [i2ctg_pkg::ODIM_W-1:0]  ra;
    logic [i2ctg_pkg::TAPS_W-1:0]  rb;
    logic [i2ctg_pkg::TAPS_W-1:0]  k_row;
    logic [i2ctg_pkg::KDIM_W-1:0]  k_col;

    always_comb
    begin
        trows_sat = (32'(tile_rows) > MAX_DIM32) ? DIM_W'(MAX_TILE_DIM) : DIM_W'(tile_rows);
        tcols_sat = (32'(tile_cols) > MAX_DIM32) ? DIM_W'(MAX_TILE_DIM) : DIM_W'(tile_cols);

        meta_next[0]       = '0;
        meta_next[0].cmd   = cmd;
        meta_next[0].waddr = write_address;
        meta_next[0].wval  = write_value;
        meta_next[0].patch = patch_index;
        meta_next[0].kidx  = kernel_index;
        meta_next[0].row0  = tile_start_row;
        meta_next[0].col0  = tile_start_col;
        meta_next[0].trows = trows_sat;
        meta_next[0].tcols = tcols_sat;
        vld_next[0]        = in_valid;

        for (int i = 1; i <= LAST; i++)
        begin
            meta_next[i] = meta_reg[i-1];
            vld_next[i]  = vld_reg[i-1];
        end

        // first divider pair done: output position, channel, range check
        meta_next[MID+1].o_row = qa;
        meta_next[MID+1].o_col = ra;
        meta_next[MID+1].chan  = qb;
        meta_next[MID+1].pad   =
            ({2'b0, meta_reg[MID].patch} >= npatch_reg) ||
            ({3'b0, meta_reg[MID].kidx} >= ktot_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                vld_reg[i] <= vld_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                meta_reg[i] <= meta_next[i];
            end
        end
    end

    i2ctg_div #(
        .NW (i2ctg_pkg::PATCH_W),
        .DW (i2ctg_pkg::ODIM_W)
    ) u_div_patch (
        .clk       (clk),
        .en        (en),
        .dividend  (meta_reg[0].patch),
        .divisor   (ow_reg),
        .quotient  (qa),
        .remainder (ra)
    );

    i2ctg_div #(
        .NW (i2ctg_pkg::PATCH_W),
        .DW (i2ctg_pkg::TAPS_W)
    ) u_div_taps (
        .clk       (clk),
        .en        (en),
        .dividend  (i2ctg_pkg::PATCH_W'(meta_reg[0].kidx)),
        .divisor   (taps_reg),
        .quotient  (qb),
        .remainder (rb)
    );

    i2ctg_div #(
        .NW (i2ctg_pkg::TAPS_W),
        .DW (i2ctg_pkg::KDIM_W)
    ) u_div_kcol (
        .clk       (clk),
        .en        (en),
        .dividend  (rb),
        .divisor   (kw_reg),
        .quotient  (k_row),
        .remainder (k_col)
    );

    // tile mapping stage
    map_t map_reg, map_next;
    logic vld_map_reg;
    logic [19:0] prod_or;
    logic [12:0] prod_oc;
    logic [13:0] prod_kr;
    logic [8:0]  prod_kc;
    logic signed [i2ctg_pkg::LOC_W-1:0] lrow_s, lcol_s;
    logic in_row, in_col;

    always_comb
    begin
        prod_or = 20'(meta_reg[LAST].o_row) * 20'(stride_reg);
        prod_oc = 13'(meta_reg[LAST].o_col) * 13'(stride_reg);
        prod_kr = 14'(k_row) * 14'(dil_reg);
        prod_kc = 9'(k_col) * 9'(dil_reg);
        lrow_s  = $signed({4'b0, prod_or}) + $signed({10'b0, prod_kr})
                - $signed({20'b0, epad_reg})
                - $signed({{12{meta_reg[LAST].row0[11]}}, meta_reg[LAST].row0});
        lcol_s  = $signed({11'b0, prod_oc}) + $signed({15'b0, prod_kc})
                - $signed({20'b0, epad_reg})
                - $signed({{12{meta_reg[LAST].col0[11]}}, meta_reg[LAST].col0});
        in_row  = !lrow_s[i2ctg_pkg::LOC_W-1] &&
                  (lrow_s < $signed({{(i2ctg_pkg::LOC_W-DIM_W){1'b0}}, meta_reg[LAST].trows}));
        in_col  = !lcol_s[i2ctg_pkg::LOC_W-1] &&
                  (lcol_s < $signed({{(i2ctg_pkg::LOC_W-DIM_W){1'b0}}, meta_reg[LAST].tcols}));

        map_next.cmd   = meta_reg[LAST].cmd;
        map_next.waddr = meta_reg[LAST].waddr;
        map_next.wval  = meta_reg[LAST].wval;
        map_next.pad   = meta_reg[LAST].pad || !in_row || !in_col;
        map_next.chan  = meta_reg[LAST].chan;
        map_next.lrow  = lrow_s[DIM_W-1:0];
        map_next.lcol  = lcol_s[DIM_W-1:0];
        map_next.tcols = meta_reg[LAST].tcols;
        map_next.area  = (2*DIM_W)'(meta_reg[LAST].trows) * (2*DIM_W)'(meta_reg[LAST].tcols);
    end

    // address stage
    acc_t acc_reg, acc_next;
    logic vld_acc_reg;
    logic [AF_W-1:0] addr_full, waddr_ext;

    always_comb
    begin
        addr_full = AF_W'(map_reg.chan) * AF_W'(map_reg.area)
                  + AF_W'(map_reg.lrow) * AF_W'(map_reg.tcols)
                  + AF_W'(map_reg.lcol);
        waddr_ext = AF_W'(map_reg.waddr);

        acc_next.cmd  = map_reg.cmd;
        acc_next.wval = map_reg.wval;
        if (map_reg.cmd == i2ctg_pkg::CMD_WRITE)
        begin
            acc_next.pad    = 1'b0;
            acc_next.beyond = (waddr_ext >= DEPTH_AF);
            acc_next.addr   = waddr_ext[ADDR_W-1:0];
        end
        else
        begin
            acc_next.pad    = map_reg.pad;
            acc_next.beyond = !map_reg.pad && (addr_full >= DEPTH_AF);
            acc_next.addr   = addr_full[ADDR_W-1:0];
        end
    end

    // scratchpad access and result
    res_t res_reg, res_next;
    logic ram_we;
    logic [i2ctg_pkg::WORD_W-1:0] ram_q;

    assign ram_we = en && vld_acc_reg && (acc_reg.cmd == i2ctg_pkg::CMD_WRITE) && !acc_reg.beyond;

    always_comb
    begin
        res_next.pad    = acc_reg.pad;
        res_next.beyond = acc_reg.beyond;
        res_next.keep   = (acc_reg.cmd == i2ctg_pkg::CMD_GATHER) && !acc_reg.pad
                       && !acc_reg.beyond;
    end

    i2ctg_ram #(
        .WIDTH (i2ctg_pkg::WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (acc_reg.addr),
        .wdata (acc_reg.wval),
        .re    (en),
        .raddr (acc_reg.addr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_map_reg   <= 1'b0;
            vld_acc_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_map_reg   <= vld_reg[LAST];
            vld_acc_reg   <= vld_map_reg;
            out_valid_reg <= vld_acc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            map_reg <= map_next;
            acc_reg <= acc_next;
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign element_value = res_reg.keep ? ram_q : '0;
    assign is_padding    = res_reg.pad;
    assign beyond_store  = res_reg.beyond;

    `I2CTG_ASSERT_IMPL(a_stall_blocks_input, clk, rst_n, out_valid && !out_ready, !in_ready, "input taken while result stalled")
    `I2CTG_ASSERT_IMPL(a_flags_exclusive, clk, rst_n, out_valid, !(is_padding && beyond_store), "padding and beyond store both set")
    `I2CTG_ASSERT_IMPL(a_value_only_kept, clk, rst_n, out_valid && (element_value != '0), !is_padding && !beyond_store, "nonzero value on flagged result")
    `I2CTG_ASSERT_NEXT(a_stall_holds_ram, clk, rst_n, out_valid && !out_ready, $stable(ram_q), "read data changed during stall")

endmodule
